FILE: hw/rtl/mald_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants of the motion-adaptive luma deinterlacer.
// Used by the channel interfaces and by every module of the block.
package mald_pkg;

	localparam int LUMA_W     = 8;
	localparam int COL_W      = 10;
	localparam int PAIR_W     = 9;
	localparam int ROW_W      = PAIR_W + 1;
	localparam int DIM_W      = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam int DEF_FRAME_WIDTH  = 768;
	localparam int DEF_FRAME_HEIGHT = 576;

	localparam logic [LUMA_W-1:0] LUMA_MAX     = 8'd255;
	localparam logic [LUMA_W-1:0] THRESH_RESET = 8'd16;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIST_KEEPS_OUT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MARK_MOTION    = 2'd2;

	typedef struct packed {
		logic [COL_W-1:0]  column;
		logic [PAIR_W-1:0] line_pair;
		logic [LUMA_W-1:0] top_luma;
		logic [LUMA_W-1:0] middle_luma;
		logic [LUMA_W-1:0] below_luma;
	} pix_in_t;

	typedef struct packed {
		logic [LUMA_W-1:0] even_luma;
		logic [LUMA_W-1:0] odd_luma;
		logic              motion_found;
	} pix_out_t;

	typedef struct packed {
		logic [LUMA_W-1:0] motion_threshold;
		logic              history_keeps_output;
		logic              mark_motion;
	} cfg_t;

	typedef struct packed {
		logic              even_we;
		logic              odd_we;
		logic [LUMA_W-1:0] even_data;
		logic [LUMA_W-1:0] odd_data;
	} hist_wr_t;

	function automatic logic [LUMA_W-1:0] absdiff(input logic [LUMA_W-1:0] a,
		input logic [LUMA_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

FILE: hw/rtl/mald_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the deinterlacer: pixel input, pixel output
// and configuration write. Depends on mald_pkg.
interface mald_pix_in_if import mald_pkg::*; ();
	logic    valid;
	logic    ready;
	pix_in_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface mald_pix_out_if import mald_pkg::*; ();
	logic     valid;
	logic     ready;
	pix_out_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface mald_cfg_if import mald_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/mald_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file of the deinterlacer, written over the cfg channel.
// Depends on mald_pkg and mald_cfg_if.
module mald_cfg_regs import mald_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	mald_cfg_if.sink      cfg,
	output cfg_t          regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.motion_threshold     <= THRESH_RESET;
			regs_q.history_keeps_output <= 1'b0;
			regs_q.mark_motion          <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_THRESHOLD:      regs_q.motion_threshold <= cfg.data[LUMA_W-1:0];
				REG_HIST_KEEPS_OUT: regs_q.history_keeps_output <= cfg.data[0];
				REG_MARK_MOTION:    regs_q.mark_motion <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/mald_history.sv
`timescale 1ns / 1ps
// Previous-frame luma store, split into an even-row bank and an odd-row bank,
// with a zero-fill sweep after reset. Depends on mald_pkg.
module mald_history import mald_pkg::*; #(
	parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
	parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT,
	localparam int EVEN_DEPTH  = ((FRAME_HEIGHT + 1) / 2) * FRAME_WIDTH,
	localparam int ODD_DEPTH   = (FRAME_HEIGHT / 2) * FRAME_WIDTH,
	localparam int ADDR_W      = $clog2(EVEN_DEPTH),
	localparam int ODD_ADDR_W  = $clog2(ODD_DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [LUMA_W-1:0] rd_even,
	output logic [LUMA_W-1:0] rd_odd,
	input  hist_wr_t          wr,
	input  logic [ADDR_W-1:0] wr_addr,
	output logic              clearing
);

	logic [LUMA_W-1:0] even_mem [EVEN_DEPTH];
	logic [LUMA_W-1:0] odd_mem [ODD_DEPTH];
	logic [LUMA_W-1:0] rd_even_q;
	logic [LUMA_W-1:0] rd_odd_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              clearing_q;
	logic              clr_odd_ok;

	assign clearing   = clearing_q;
	assign rd_even    = rd_even_q;
	assign rd_odd     = rd_odd_q;
	assign clr_odd_ok = {1'b0, clr_addr_q} < (ADDR_W + 1)'(ODD_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == ADDR_W'(EVEN_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			even_mem[clr_addr_q] <= '0;
		end else if (wr.even_we) begin
			even_mem[wr_addr] <= wr.even_data;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			if (clr_odd_ok) begin
				odd_mem[clr_addr_q[ODD_ADDR_W-1:0]] <= '0;
			end
		end else if (wr.odd_we) begin
			odd_mem[wr_addr[ODD_ADDR_W-1:0]] <= wr.odd_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_even_q <= even_mem[rd_addr];
			rd_odd_q  <= odd_mem[rd_addr[ODD_ADDR_W-1:0]];
		end
	end

endmodule

FILE: hw/rtl/motion_adaptive_luma_deinterlacer.sv
`timescale 1ns / 1ps
// Motion-adaptive luma deinterlacer top level: four-stage pipeline around the history store.
// An accepted item moves through stages s1 to s4 and is driven on pix_out from s4. One
// transaction per cycle is sustained while pix_out is ready, set by the one read and one
// write port per bank; a stall on pix_out holds all stages in place. After reset the store
// is zero-filled over its ceil(FRAME_HEIGHT/2)*FRAME_WIDTH even-bank addresses (221184 at
// 768x576) with pix_in held off. Depends on mald_pkg, mald_if, mald_cfg_regs, mald_history.
module motion_adaptive_luma_deinterlacer import mald_pkg::*; #(
	parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
	parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
	input  logic            clk,
	input  logic            arst_n,
	mald_cfg_if.sink        cfg,
	mald_pix_in_if.sink     pix_in,
	mald_pix_out_if.source  pix_out
);

	localparam int EVEN_DEPTH = ((FRAME_HEIGHT + 1) / 2) * FRAME_WIDTH;
	localparam int ADDR_W     = $clog2(EVEN_DEPTH);
	localparam int FULL_W     = PAIR_W + DIM_W;

	cfg_t              regs;
	hist_wr_t          wr;
	logic              clearing;
	logic              adv;
	logic              acc;
	logic [LUMA_W-1:0] rd_even;
	logic [LUMA_W-1:0] rd_odd;

	logic [FULL_W-1:0] addr_full;
	logic              col_ok;
	logic              even_ok;
	logic              odd_ok;

	logic              valid_s1, valid_s2, valid_s3, valid_s4;
	pix_in_t           item_s1, item_s2;
	logic [ADDR_W-1:0] addr_s1, addr_s2, addr_s3, addr_s4;
	logic              even_ok_s1, even_ok_s2, even_ok_s3, even_ok_s4;
	logic              odd_ok_s1, odd_ok_s2, odd_ok_s3, odd_ok_s4;

	logic [LUMA_W-1:0] h_even;
	logic [LUMA_W-1:0] h_odd;
	logic [LUMA_W:0]   sum;

	logic [LUMA_W-1:0] top_s3, mid_s3, avg_s3, dm_s3, d0_s3, d1_s3;
	logic              keep;
	logic [LUMA_W-1:0] odd_hist;
	logic [LUMA_W-1:0] odd_out;

	pix_out_t          out_s4;
	logic [LUMA_W-1:0] odd_hist_s4;

	mald_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	mald_history #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_hist (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (adv),
		.rd_addr  (addr_s1),
		.rd_even  (rd_even),
		.rd_odd   (rd_odd),
		.wr       (wr),
		.wr_addr  (addr_s3),
		.clearing (clearing)
	);

	assign adv          = !valid_s4 || pix_out.ready;
	assign pix_in.ready = adv && !clearing;
	assign acc          = pix_in.valid && pix_in.ready;

	assign addr_full = FULL_W'(pix_in.item.line_pair) * FULL_W'(FRAME_WIDTH)
		+ FULL_W'(pix_in.item.column);
	assign col_ok  = {{(DIM_W - COL_W){1'b0}}, pix_in.item.column} < DIM_W'(FRAME_WIDTH);
	assign even_ok = col_ok && ({{(DIM_W - ROW_W){1'b0}}, pix_in.item.line_pair, 1'b0}
		< DIM_W'(FRAME_HEIGHT));
	assign odd_ok  = col_ok && ({{(DIM_W - ROW_W){1'b0}}, pix_in.item.line_pair, 1'b1}
		< DIM_W'(FRAME_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= acc;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1    <= pix_in.item;
			addr_s1    <= addr_full[ADDR_W-1:0];
			even_ok_s1 <= even_ok;
			odd_ok_s1  <= odd_ok;

			item_s2    <= item_s1;
			addr_s2    <= addr_s1;
			even_ok_s2 <= even_ok_s1;
			odd_ok_s2  <= odd_ok_s1;
		end
	end

	// History for the item in stage two; writes of the two items ahead of it
	// are not yet visible in the registered read data and are forwarded.
	always_comb begin
		h_even = '0;
		if (even_ok_s2) begin
			if (valid_s3 && even_ok_s3 && addr_s3 == addr_s2) begin
				h_even = top_s3;
			end else if (valid_s4 && even_ok_s4 && addr_s4 == addr_s2) begin
				h_even = out_s4.even_luma;
			end else begin
				h_even = rd_even;
			end
		end
		h_odd = '0;
		if (odd_ok_s2) begin
			if (valid_s3 && odd_ok_s3 && addr_s3 == addr_s2) begin
				h_odd = odd_hist;
			end else if (valid_s4 && odd_ok_s4 && addr_s4 == addr_s2) begin
				h_odd = odd_hist_s4;
			end else begin
				h_odd = rd_odd;
			end
		end
	end

	assign sum = {1'b0, item_s2.top_luma} + {1'b0, item_s2.below_luma} + (LUMA_W + 1)'(1);

	always_ff @(posedge clk) begin
		if (adv) begin
			top_s3     <= item_s2.top_luma;
			mid_s3     <= item_s2.middle_luma;
			avg_s3     <= sum[LUMA_W:1];
			dm_s3      <= absdiff(item_s2.middle_luma, item_s2.top_luma);
			d0_s3      <= absdiff(h_odd, item_s2.middle_luma);
			d1_s3      <= absdiff(h_even, item_s2.top_luma);
			addr_s3    <= addr_s2;
			even_ok_s3 <= even_ok_s2;
			odd_ok_s3  <= odd_ok_s2;
		end
	end

	assign keep = (dm_s3 < regs.motion_threshold)
		|| (d0_s3 <= regs.motion_threshold && d1_s3 <= regs.motion_threshold);
	assign odd_hist = (keep || !regs.history_keeps_output) ? mid_s3 : avg_s3;
	assign odd_out  = keep ? mid_s3 : (regs.mark_motion ? LUMA_MAX : avg_s3);

	assign wr.even_we   = adv && valid_s3 && even_ok_s3;
	assign wr.odd_we    = adv && valid_s3 && odd_ok_s3;
	assign wr.even_data = top_s3;
	assign wr.odd_data  = odd_hist;

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s4.even_luma    <= top_s3;
			out_s4.odd_luma     <= odd_out;
			out_s4.motion_found <= !keep;
			odd_hist_s4         <= odd_hist;
			addr_s4             <= addr_s3;
			even_ok_s4          <= even_ok_s3;
			odd_ok_s4           <= odd_ok_s3;
		end
	end

	assign pix_out.valid = valid_s4;
	assign pix_out.item  = out_s4;

`ifndef NO_ASSERTIONS
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !pix_in.ready)
		else $error("input accepted during the history clearing sweep");

	a_clear_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !(valid_s1 || valid_s2 || valid_s3 || valid_s4))
		else $error("pipeline holds a transaction during the clearing sweep");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> valid_s4 && $stable(out_s4) && $stable(valid_s3) && $stable(addr_s3))
		else $error("pipeline moved while the output was stalled");
`endif

endmodule
